// ===== src/pat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants for the per-address traffic accounting block.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int TOT_W = 32;
    localparam int LEN_W = 16;
    localparam int MIN_W = 6;

    localparam logic [MIN_W-1:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [MIN_W-1:0] WINDOW_RESET     = 6'd1;

    typedef struct packed {
        logic [MAC_W-1:0] src_mac;
        logic [MAC_W-1:0] dst_mac;
        logic [IP_W-1:0]  src_ip;
        logic [IP_W-1:0]  dst_ip;
        logic [LEN_W-1:0] ip_total_length;
        logic [MIN_W-1:0] minute;
    } pat_in_t;

    typedef struct packed {
        logic             direction;
        logic [MAC_W-1:0] mac_address;
        logic [IP_W-1:0]  ip_address;
        logic [TOT_W-1:0] total_bytes;
        logic             table_overflow;
        logic             last;
    } pat_out_t;

    // one table entry as read from the memories
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        logic [TOT_W-1:0] total;
    } pat_entry_t;

    // lookup request handed to a table
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        logic [LEN_W-1:0] len;
    } pat_req_t;

    typedef struct packed {
        logic busy;
        logic dropped;
    } pat_tbl_status_t;

    typedef enum logic {
        TBL_IDLE,
        TBL_SCAN
    } pat_tbl_state_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_ACCT,
        CTL_REP_RD,
        CTL_REP_LOAD
    } pat_ctl_state_t;

endpackage

// ===== src/pat_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_table
// One address table: MAC, IP and byte total memories with a sequential
// search, saturating read-modify-write of the total, append on miss if not full.
// ----------------------------------------------------------------------------
module pat_table #(
    parameter int ENTRIES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  pat_pkg::pat_req_t             req,
    input  logic                          clear,
    input  logic                          rd_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output pat_pkg::pat_entry_t           rd_data,
    output logic [$clog2(ENTRIES+1)-1:0]  count,
    output pat_pkg::pat_tbl_status_t      status
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [pat_pkg::MAC_W-1:0] mac_mem [ENTRIES];
    logic [pat_pkg::IP_W-1:0]  ip_mem  [ENTRIES];
    logic [pat_pkg::TOT_W-1:0] tot_mem [ENTRIES];

    pat_pkg::pat_tbl_state_t state_reg, state_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    pend_reg, pend_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    dropped_reg, dropped_next;
    logic [IW-1:0]           pend_idx_reg, pend_idx_next;
    pat_pkg::pat_req_t       req_reg;
    pat_pkg::pat_entry_t     rd_data_reg;

    logic                      hit;
    logic                      scan_done;
    logic                      issue;
    logic                      table_full;
    logic                      ins_we;
    logic                      upd_we;
    logic [pat_pkg::TOT_W:0]   sum;
    logic [pat_pkg::TOT_W-1:0] sat_total;
    logic [IW-1:0]             rd_idx;
    logic [IW-1:0]             tot_wa;
    logic [pat_pkg::TOT_W-1:0] tot_wd;

    assign table_full = (count_reg == CW'(ENTRIES));
    assign hit        = pend_reg && (rd_data_reg.mac == req_reg.mac);
    assign scan_done  = (idx_reg == count_reg);
    assign issue      = (state_reg == pat_pkg::TBL_SCAN) && !hit && !scan_done;
    assign upd_we     = (state_reg == pat_pkg::TBL_SCAN) && hit;
    assign ins_we     = (state_reg == pat_pkg::TBL_SCAN) && !hit && scan_done && !table_full;

    assign sum       = {1'b0, rd_data_reg.total} +
                       {{(pat_pkg::TOT_W + 1 - pat_pkg::LEN_W){1'b0}}, req_reg.len};
    assign sat_total = sum[pat_pkg::TOT_W] ? '1 : sum[pat_pkg::TOT_W-1:0];

    assign rd_idx = (state_reg == pat_pkg::TBL_SCAN) ? idx_reg[IW-1:0] : rd_addr;
    assign tot_wa = ins_we ? count_reg[IW-1:0] : pend_idx_reg;
    assign tot_wd = ins_we ? {{(pat_pkg::TOT_W - pat_pkg::LEN_W){1'b0}}, req_reg.len}
                           : sat_total;

    // memories: one write port each, one registered read port shared by
    // search and report
    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            mac_mem[count_reg[IW-1:0]] <= req_reg.mac;
            ip_mem[count_reg[IW-1:0]]  <= req_reg.ip;
        end
        if (ins_we || upd_we)
        begin
            tot_mem[tot_wa] <= tot_wd;
        end
        if (issue || rd_en)
        begin
            rd_data_reg.mac   <= mac_mem[rd_idx];
            rd_data_reg.ip    <= ip_mem[rd_idx];
            rd_data_reg.total <= tot_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= req;
        end
        pend_idx_reg <= pend_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pat_pkg::TBL_IDLE;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        unique case (state_reg)
            pat_pkg::TBL_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    state_next = pat_pkg::TBL_SCAN;
                end
            end
            pat_pkg::TBL_SCAN:
            begin
                // read of entry idx issued now, compared next cycle
                pend_next = issue;
                if (issue)
                begin
                    idx_next      = idx_reg + CW'(1);
                    pend_idx_next = idx_reg[IW-1:0];
                end
                if (hit)
                begin
                    state_next = pat_pkg::TBL_IDLE;
                end
                else if (scan_done)
                begin
                    if (table_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    state_next = pat_pkg::TBL_IDLE;
                end
            end
            default:
            begin
                state_next = pat_pkg::TBL_IDLE;
            end
        endcase
        if (clear)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    assign rd_data        = rd_data_reg;
    assign count          = count_reg;
    assign status.busy    = (state_reg != pat_pkg::TBL_IDLE);
    assign status.dropped = dropped_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("table count beyond capacity");

    a_dropped_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> table_full)
        else $error("drop flag set while table has room");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == pat_pkg::TBL_IDLE))
        else $error("lookup started while search in progress");

endmodule

// ===== src/per_address_traffic_accounting.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_address_traffic_accounting
// Per-MAC byte accounting over a minute window, source and destination
// tables, with a full report of both tables when the window expires.
// ----------------------------------------------------------------------------
//  channel  | signals                      | beat
//  ---------+------------------------------+-------------------------------
//  cfg      | cfg_we, cfg_wdata            | window_minutes write
//  in       | in_valid, in_stall, in_data  | one packet header
//  out      | out_valid, out_stall, out_data | one reported table entry
//
// A packet's search time grows with the entries already in the larger table;
// the sequential MAC search through each table's memory read port sets
// this. A report reads each entry through the shared read port, in states
// CTL_REP_RD then CTL_REP_LOAD, and also waits while out_stall is held.
// Reset clears entry counts and flags; table memories need no clearing.
// A result waits in the output register while the next packet is taken.
// ----------------------------------------------------------------------------
module per_address_traffic_accounting #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pat_pkg::MIN_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  pat_pkg::pat_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pat_pkg::pat_out_t           out_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    pat_pkg::pat_ctl_state_t state_reg, state_next;
    logic [pat_pkg::MIN_W-1:0] window_reg;
    logic                      open_reg, open_next;
    logic [pat_pkg::MIN_W-1:0] start_min_reg, start_min_next;
    logic [pat_pkg::MIN_W-1:0] minute_reg;
    logic                      dir_reg, dir_next;
    logic [IW-1:0]             ptr_reg, ptr_next;
    logic                      out_valid_reg, out_valid_next;
    pat_pkg::pat_out_t         out_reg, out_next;

    logic                      accept;
    logic [pat_pkg::MIN_W-1:0] min_mod;
    logic [pat_pkg::MIN_W:0]   elapsed_raw;
    logic [pat_pkg::MIN_W-1:0] elapsed;
    logic                      report_due;
    logic                      clear;
    logic                      rd_en;
    logic                      load_ok;
    logic                      at_end;
    logic                      last_item;
    logic [CW-1:0]             cur_count;

    pat_pkg::pat_req_t         src_req, dst_req;
    pat_pkg::pat_entry_t       src_rd, dst_rd, cur_rd;
    logic [CW-1:0]             src_count, dst_count;
    pat_pkg::pat_tbl_status_t  src_status, dst_status;

    assign in_stall = (state_reg != pat_pkg::CTL_IDLE);
    assign accept   = in_valid && !in_stall;

    assign min_mod = (in_data.minute >= pat_pkg::MINUTES_PER_HOUR)
                   ? in_data.minute - pat_pkg::MINUTES_PER_HOUR : in_data.minute;

    assign elapsed_raw = {1'b0, minute_reg} + {1'b0, pat_pkg::MINUTES_PER_HOUR}
                       - {1'b0, start_min_reg};
    assign elapsed     = (elapsed_raw >= {1'b0, pat_pkg::MINUTES_PER_HOUR})
                       ? elapsed_raw[pat_pkg::MIN_W-1:0] - pat_pkg::MINUTES_PER_HOUR
                       : elapsed_raw[pat_pkg::MIN_W-1:0];
    assign report_due  = (elapsed >= window_reg);

    assign src_req.mac = in_data.src_mac;
    assign src_req.ip  = in_data.src_ip;
    assign src_req.len = in_data.ip_total_length;
    assign dst_req.mac = in_data.dst_mac;
    assign dst_req.ip  = in_data.dst_ip;
    assign dst_req.len = in_data.ip_total_length;

    pat_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_src_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .req     (src_req),
        .clear   (clear),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (src_rd),
        .count   (src_count),
        .status  (src_status)
    );

    pat_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_dst_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .req     (dst_req),
        .clear   (clear),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (dst_rd),
        .count   (dst_count),
        .status  (dst_status)
    );

    assign cur_count = dir_reg ? dst_count : src_count;
    assign cur_rd    = dir_reg ? dst_rd : src_rd;
    assign at_end    = ((CW'(ptr_reg) + CW'(1)) == cur_count);
    assign last_item = at_end && (dir_reg || (dst_count == '0));
    assign load_ok   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            minute_reg <= min_mod;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pat_pkg::CTL_IDLE;
            window_reg    <= pat_pkg::WINDOW_RESET;
            open_reg      <= 1'b0;
            start_min_reg <= '0;
            dir_reg       <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            start_min_reg <= start_min_next;
            dir_reg       <= dir_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        start_min_next = start_min_reg;
        dir_next       = dir_reg;
        ptr_next       = ptr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        clear          = 1'b0;
        rd_en          = 1'b0;
        unique case (state_reg)
            pat_pkg::CTL_IDLE:
            begin
                if (accept)
                begin
                    if (!open_reg)
                    begin
                        open_next      = 1'b1;
                        start_min_next = min_mod;
                    end
                    state_next = pat_pkg::CTL_ACCT;
                end
            end
            pat_pkg::CTL_ACCT:
            begin
                if (!src_status.busy && !dst_status.busy)
                begin
                    if (report_due)
                    begin
                        dir_next   = (src_count == '0);
                        ptr_next   = '0;
                        state_next = pat_pkg::CTL_REP_RD;
                    end
                    else
                    begin
                        state_next = pat_pkg::CTL_IDLE;
                    end
                end
            end
            pat_pkg::CTL_REP_RD:
            begin
                rd_en      = 1'b1;
                state_next = pat_pkg::CTL_REP_LOAD;
            end
            pat_pkg::CTL_REP_LOAD:
            begin
                if (load_ok)
                begin
                    out_next.direction      = dir_reg;
                    out_next.mac_address    = cur_rd.mac;
                    out_next.ip_address     = cur_rd.ip;
                    out_next.total_bytes    = cur_rd.total;
                    out_next.table_overflow = dir_reg ? dst_status.dropped
                                                      : src_status.dropped;
                    out_next.last           = last_item;
                    out_valid_next          = 1'b1;
                    if (!at_end)
                    begin
                        ptr_next   = ptr_reg + IW'(1);
                        state_next = pat_pkg::CTL_REP_RD;
                    end
                    else if (!dir_reg && (dst_count != '0))
                    begin
                        dir_next   = 1'b1;
                        ptr_next   = '0;
                        state_next = pat_pkg::CTL_REP_RD;
                    end
                    else
                    begin
                        // report finished: drop tables and window
                        clear          = 1'b1;
                        open_next      = 1'b0;
                        start_min_next = '0;
                        state_next     = pat_pkg::CTL_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pat_pkg::CTL_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_tables_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!src_status.busy && !dst_status.busy))
        else $error("packet accepted while a table search runs");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> ((src_count == '0) && (dst_count == '0)))
        else $error("entries present with no open window");

    a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pat_pkg::CTL_REP_LOAD) && load_ok && last_item)
        |=> (state_reg == pat_pkg::CTL_IDLE && !open_reg))
        else $error("report continued past its final beat");

endmodule
